// ===== rtl/hrqp_pkg.sv =====
package hrqp_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [2:0] FuncKeyboard = 3'd0;
  localparam logic [2:0] FuncMouse    = 3'd1;
  localparam logic [2:0] FuncConsumer = 3'd2;
  localparam logic [2:0] FuncRelease  = 3'd3;
  localparam logic [2:0] FuncTick     = 3'd4;

  localparam logic [9:0] RateReset = 10'd1000;
  localparam logic [9:0] Rate125   = 10'd125;
  localparam logic [9:0] Rate250   = 10'd250;
  localparam logic [9:0] Rate500   = 10'd500;
  localparam logic [9:0] Rate1000  = 10'd1000;

  localparam logic signed [8:0] ClampHi = 9'sd127;
  localparam logic signed [8:0] ClampLo = -9'sd127;

  typedef struct packed {
    logic [2:0]        func;
    logic [63:0]       keyboard_report;
    logic [7:0]        mouse_buttons;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
    logic signed [7:0] mouse_wheel;
    logic [15:0]       consumer_usage;
    logic [15:0]       elapsed_ticks;
    logic              usb_configured;
    logic              keyboard_ready;
    logic              mouse_ready;
    logic              consumer_ready;
  } in_t;

  typedef struct packed {
    logic              keyboard_sent;
    logic [63:0]       sent_keyboard_report;
    logic              mouse_sent;
    logic [7:0]        sent_buttons;
    logic signed [7:0] sent_dx;
    logic signed [7:0] sent_dy;
    logic signed [7:0] sent_wheel;
    logic              consumer_sent;
    logic [15:0]       sent_consumer_usage;
  } out_t;

  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] a,
                                               input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {{(CntW + 1 - PtrW){1'b0}}, a} + {1'b0, b};
    if (s >= (CntW + 1)'(QueueDepth)) begin
      s = s - (CntW + 1)'(QueueDepth);
    end
    return s[PtrW-1:0];
  endfunction

endpackage

// ===== rtl/hrqp_ram.sv =====
module hrqp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hrqp_ctrl.sv =====
module hrqp_ctrl
  import hrqp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_commit;

  assign in_ready_o  = (state_q == StIdle);
  assign can_commit  = (state_q == StExec) && (!out_valid_q || out_ready_i);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.commit = can_commit;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StExec;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        StExec: begin
          if (can_commit) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hrqp_dp.sv =====
module hrqp_dp
  import hrqp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  in_t        in_data_i,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  output out_t       out_data_o
);

  in_t            item_q;
  out_t           out_q, out_d;
  logic [PtrW-1:0] kb_head_q, kb_head_d, ms_head_q, ms_head_d, cc_head_q, cc_head_d;
  logic [CntW-1:0] kb_cnt_q, kb_cnt_d, ms_cnt_q, ms_cnt_d, cc_cnt_q, cc_cnt_d;
  logic [14:0]     phase_q, phase_d;
  logic [9:0]      rate_q;

  logic            kb_full, ms_full, cc_full;
  logic [PtrW-1:0] kb_slot, ms_slot, cc_slot, ms_raddr;
  logic [63:0]     kb_rdata, kb_wdata;
  logic [31:0]     ms_rdata, ms_wdata;
  logic [15:0]     cc_rdata, cc_wdata;
  logic            kb_we, ms_we, cc_we;
  logic [PtrW-1:0] kb_waddr, ms_waddr, cc_waddr;
  logic [25:0]     prod;
  logic [26:0]     phase_sum;
  logic            rate_ok;

  function automatic logic [7:0] clamp_add(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0] s;
    s = $signed({a[7], a}) + $signed({b[7], b});
    if (s > ClampHi) begin
      s = ClampHi;
    end else if (s < ClampLo) begin
      s = ClampLo;
    end
    return s[7:0];
  endfunction

  assign kb_full = (kb_cnt_q == CntW'(QueueDepth));
  assign ms_full = (ms_cnt_q == CntW'(QueueDepth));
  assign cc_full = (cc_cnt_q == CntW'(QueueDepth));
  assign kb_slot = kb_full ? wrap_add(kb_head_q, CntW'(QueueDepth - 1)) :
                   wrap_add(kb_head_q, kb_cnt_q);
  assign ms_slot = ms_full ? wrap_add(ms_head_q, CntW'(QueueDepth - 1)) :
                   wrap_add(ms_head_q, ms_cnt_q);
  assign cc_slot = cc_full ? wrap_add(cc_head_q, CntW'(QueueDepth - 1)) :
                   wrap_add(cc_head_q, cc_cnt_q);
  assign ms_raddr = (in_data_i.func == FuncMouse) ? ms_slot : ms_head_q;

  hrqp_ram #(.Width(64), .Depth(QueueDepth)) u_kb_ram (
    .clk_i, .we_i(kb_we), .waddr_i(kb_waddr), .wdata_i(kb_wdata),
    .re_i(cmd_i.load), .raddr_i(kb_head_q), .rdata_o(kb_rdata)
  );
  hrqp_ram #(.Width(32), .Depth(QueueDepth)) u_ms_ram (
    .clk_i, .we_i(ms_we), .waddr_i(ms_waddr), .wdata_i(ms_wdata),
    .re_i(cmd_i.load), .raddr_i(ms_raddr), .rdata_o(ms_rdata)
  );
  hrqp_ram #(.Width(16), .Depth(QueueDepth)) u_cc_ram (
    .clk_i, .we_i(cc_we), .waddr_i(cc_waddr), .wdata_i(cc_wdata),
    .re_i(cmd_i.load), .raddr_i(cc_head_q), .rdata_o(cc_rdata)
  );

  assign prod      = {10'd0, item_q.elapsed_ticks} * {16'd0, rate_q};
  assign phase_sum = {12'd0, phase_q} + {1'b0, prod};
  assign rate_ok   = (cfg_wdata_i == Rate125) || (cfg_wdata_i == Rate250) ||
                     (cfg_wdata_i == Rate500) || (cfg_wdata_i == Rate1000);

  always_comb begin
    kb_head_d = kb_head_q;
    ms_head_d = ms_head_q;
    cc_head_d = cc_head_q;
    kb_cnt_d  = kb_cnt_q;
    ms_cnt_d  = ms_cnt_q;
    cc_cnt_d  = cc_cnt_q;
    phase_d   = phase_q;
    out_d     = '0;
    kb_we     = 1'b0;
    ms_we     = 1'b0;
    cc_we     = 1'b0;
    kb_waddr  = kb_slot;
    ms_waddr  = ms_slot;
    cc_waddr  = cc_slot;
    kb_wdata  = item_q.keyboard_report;
    cc_wdata  = item_q.consumer_usage;
    ms_wdata  = {item_q.mouse_wheel, item_q.mouse_dy, item_q.mouse_dx,
                 item_q.mouse_buttons};
    if (ms_full) begin
      ms_wdata = {clamp_add(ms_rdata[31:24], item_q.mouse_wheel),
                  clamp_add(ms_rdata[23:16], item_q.mouse_dy),
                  clamp_add(ms_rdata[15:8], item_q.mouse_dx),
                  item_q.mouse_buttons};
    end
    if (cmd_i.commit) begin
      unique case (item_q.func)
        FuncKeyboard: begin
          kb_we = 1'b1;
          if (!kb_full) kb_cnt_d = kb_cnt_q + CntW'(1);
        end
        FuncMouse: begin
          ms_we = 1'b1;
          if (!ms_full) ms_cnt_d = ms_cnt_q + CntW'(1);
        end
        FuncConsumer: begin
          cc_we = 1'b1;
          if (!cc_full) cc_cnt_d = cc_cnt_q + CntW'(1);
        end
        FuncRelease: begin
          kb_we     = 1'b1;
          ms_we     = 1'b1;
          cc_we     = 1'b1;
          kb_waddr  = '0;
          ms_waddr  = '0;
          cc_waddr  = '0;
          kb_wdata  = '0;
          ms_wdata  = '0;
          cc_wdata  = '0;
          kb_head_d = '0;
          ms_head_d = '0;
          cc_head_d = '0;
          kb_cnt_d  = CntW'(1);
          ms_cnt_d  = CntW'(1);
          cc_cnt_d  = CntW'(1);
        end
        FuncTick: begin
          if (!item_q.usb_configured) begin
            phase_d = '0;
          end else begin
            phase_d = phase_sum[14:0];
            if (phase_sum[26:15] != '0) begin
              if (kb_cnt_q != '0 && item_q.keyboard_ready) begin
                out_d.keyboard_sent        = 1'b1;
                out_d.sent_keyboard_report = kb_rdata;
                kb_head_d = wrap_add(kb_head_q, CntW'(1));
                kb_cnt_d  = kb_cnt_q - CntW'(1);
              end
              if (ms_cnt_q != '0 && item_q.mouse_ready) begin
                out_d.mouse_sent   = 1'b1;
                out_d.sent_buttons = ms_rdata[7:0];
                out_d.sent_dx      = ms_rdata[15:8];
                out_d.sent_dy      = ms_rdata[23:16];
                out_d.sent_wheel   = ms_rdata[31:24];
                ms_head_d = wrap_add(ms_head_q, CntW'(1));
                ms_cnt_d  = ms_cnt_q - CntW'(1);
              end
              if (cc_cnt_q != '0 && item_q.consumer_ready) begin
                out_d.consumer_sent       = 1'b1;
                out_d.sent_consumer_usage = cc_rdata;
                cc_head_d = wrap_add(cc_head_q, CntW'(1));
                cc_cnt_d  = cc_cnt_q - CntW'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_head_q <= '0;
      ms_head_q <= '0;
      cc_head_q <= '0;
      kb_cnt_q  <= '0;
      ms_cnt_q  <= '0;
      cc_cnt_q  <= '0;
      phase_q   <= '0;
      rate_q    <= RateReset;
    end else begin
      kb_head_q <= kb_head_d;
      ms_head_q <= ms_head_d;
      cc_head_q <= cc_head_d;
      kb_cnt_q  <= kb_cnt_d;
      ms_cnt_q  <= ms_cnt_d;
      cc_cnt_q  <= cc_cnt_d;
      phase_q   <= phase_d;
      if (cfg_we_i && rate_ok) begin
        rate_q  <= cfg_wdata_i;
        phase_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/hid_report_queue_pacer_unit.sv =====
// Report queue and pacer for keyboard, mouse and consumer-control reports.
// Input transactions carry one command: queue a keyboard, mouse or consumer
// report, release all keys, or a timer tick that may pop one report of each
// kind toward the host side. Each input transaction yields exactly one output
// transaction holding the popped reports and their sent flags.
// An accepted transaction is latched, the queue memories are read in the same
// cycle, and the update and result are committed in the state after, once the
// output register is free or being taken. A new transaction is taken only
// after the previous one is committed, since the registered read of the
// queue memories comes ahead of the read-modify-write of the newest mouse entry.
// The output register holds its result until the receiver takes it. A
// stalled receiver holds the next commit back, but a new input is still
// accepted while the previous result waits.
// The poll rate register is written with cfg_we_i; only 125, 250, 500 and
// 1000 are taken, and a taken write clears the phase. Reset empties all
// queues, clears the phase and sets the rate to 1000. Queue memories need
// no clearing pass.
module hid_report_queue_pacer_unit
  import hrqp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i
);

  cmd_t cmd;

  hrqp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  hrqp_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_data_i, .cfg_we_i, .cfg_wdata_i,
    .out_data_o
  );

endmodule

// ===== rtl/hrqp_checker.sv =====
module hrqp_checker
  import hrqp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output transaction dropped before acceptance.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted on back-to-back cycles.");

  a_kb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.keyboard_sent |-> out_data_o.sent_keyboard_report == '0)
    else $error("Keyboard report not zero without sent flag.");

  a_cc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.consumer_sent |-> out_data_o.sent_consumer_usage == '0)
    else $error("Consumer report not zero without sent flag.");

endmodule

bind hid_report_queue_pacer_unit hrqp_checker u_hrqp_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hrqp_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_t       out_data_o;
  logic       cfg_we_i;
  logic [9:0] cfg_wdata_i;

  hid_report_queue_pacer_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow state of the queues and pacer.
  logic [63:0] kb_mem [QueueDepth];
  logic [31:0] ms_mem [QueueDepth];
  logic [15:0] cc_mem [QueueDepth];
  int unsigned kb_hd, kb_cnt, ms_hd, ms_cnt, cc_hd, cc_cnt;
  logic [31:0] phase;
  logic [9:0]  rate;

  in_t  pending_items[$];
  out_t sent_reports[$];
  int   errors;
  int   send_idle_pct, recv_idle_pct;
  int   recv_hold;
  logic in_taken;

  function automatic logic [7:0] sat_sum(logic [7:0] a, logic [7:0] b);
    int s;
    s = int'($signed(a)) + int'($signed(b));
    if (s > 127) s = 127;
    if (s < -127) s = -127;
    return 8'(s);
  endfunction

  function automatic void shadow_clear();
    kb_hd = 0; kb_cnt = 0; ms_hd = 0; ms_cnt = 0; cc_hd = 0; cc_cnt = 0;
  endfunction

  function automatic void kb_put(logic [63:0] r);
    if (kb_cnt >= QueueDepth) kb_mem[PtrW'((kb_hd + QueueDepth - 1) % QueueDepth)] = r;
    else begin
      kb_mem[PtrW'((kb_hd + kb_cnt) % QueueDepth)] = r;
      kb_cnt++;
    end
  endfunction

  function automatic void ms_put(logic [31:0] r);
    logic [PtrW-1:0] i;
    logic [31:0] q;
    if (ms_cnt >= QueueDepth) begin
      i = PtrW'((ms_hd + QueueDepth - 1) % QueueDepth);
      q = ms_mem[i];
      ms_mem[i] = {sat_sum(q[31:24], r[31:24]), sat_sum(q[23:16], r[23:16]),
                   sat_sum(q[15:8], r[15:8]), r[7:0]};
    end else begin
      ms_mem[PtrW'((ms_hd + ms_cnt) % QueueDepth)] = r;
      ms_cnt++;
    end
  endfunction

  function automatic void cc_put(logic [15:0] r);
    if (cc_cnt >= QueueDepth) cc_mem[PtrW'((cc_hd + QueueDepth - 1) % QueueDepth)] = r;
    else begin
      cc_mem[PtrW'((cc_hd + cc_cnt) % QueueDepth)] = r;
      cc_cnt++;
    end
  endfunction

  function automatic out_t pace_report(in_t it);
    out_t o;
    logic [31:0] m;
    o = '0;
    case (it.func)
      FuncKeyboard: kb_put(it.keyboard_report);
      FuncMouse: ms_put({it.mouse_wheel, it.mouse_dy, it.mouse_dx, it.mouse_buttons});
      FuncConsumer: cc_put(it.consumer_usage);
      FuncRelease: begin
        shadow_clear();
        kb_put('0);
        ms_put('0);
        cc_put('0);
      end
      FuncTick: begin
        if (!it.usb_configured) phase = 0;
        else begin
          phase = phase + it.elapsed_ticks * rate;
          if (phase >= 32768) begin
            phase = phase % 32768;
            if (kb_cnt != 0 && it.keyboard_ready) begin
              o.keyboard_sent = 1'b1;
              o.sent_keyboard_report = kb_mem[PtrW'(kb_hd)];
              kb_hd = (kb_hd + 1) % QueueDepth;
              kb_cnt--;
            end
            if (ms_cnt != 0 && it.mouse_ready) begin
              m = ms_mem[PtrW'(ms_hd)];
              o.mouse_sent = 1'b1;
              {o.sent_wheel, o.sent_dy, o.sent_dx, o.sent_buttons} = m;
              ms_hd = (ms_hd + 1) % QueueDepth;
              ms_cnt--;
            end
            if (cc_cnt != 0 && it.consumer_ready) begin
              o.consumer_sent = 1'b1;
              o.sent_consumer_usage = cc_mem[PtrW'(cc_hd)];
              cc_hd = (cc_hd + 1) % QueueDepth;
              cc_cnt--;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Driver: a transaction is predicted when it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sent_reports.push_back(pace_report(in_data_i));
      void'(pending_items.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      // Either idle or the previous transaction was accepted at the last edge.
      in_taken = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      out_ready_i <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sent_reports.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
      end else begin
        e = sent_reports.pop_front();
        if (out_data_o.keyboard_sent !== e.keyboard_sent) begin
          $error("keyboard_sent exp %0h got %0h", e.keyboard_sent, out_data_o.keyboard_sent);
          errors++;
        end
        if (out_data_o.sent_keyboard_report !== e.sent_keyboard_report) begin
          $error("sent_keyboard_report exp %0h got %0h", e.sent_keyboard_report,
                 out_data_o.sent_keyboard_report);
          errors++;
        end
        if (out_data_o.mouse_sent !== e.mouse_sent) begin
          $error("mouse_sent exp %0h got %0h", e.mouse_sent, out_data_o.mouse_sent);
          errors++;
        end
        if (out_data_o.sent_buttons !== e.sent_buttons) begin
          $error("sent_buttons exp %0h got %0h", e.sent_buttons, out_data_o.sent_buttons);
          errors++;
        end
        if (out_data_o.sent_dx !== e.sent_dx) begin
          $error("sent_dx exp %0d got %0d", e.sent_dx, out_data_o.sent_dx);
          errors++;
        end
        if (out_data_o.sent_dy !== e.sent_dy) begin
          $error("sent_dy exp %0d got %0d", e.sent_dy, out_data_o.sent_dy);
          errors++;
        end
        if (out_data_o.sent_wheel !== e.sent_wheel) begin
          $error("sent_wheel exp %0d got %0d", e.sent_wheel, out_data_o.sent_wheel);
          errors++;
        end
        if (out_data_o.consumer_sent !== e.consumer_sent) begin
          $error("consumer_sent exp %0h got %0h", e.consumer_sent, out_data_o.consumer_sent);
          errors++;
        end
        if (out_data_o.sent_consumer_usage !== e.sent_consumer_usage) begin
          $error("sent_consumer_usage exp %0h got %0h", e.sent_consumer_usage,
                 out_data_o.sent_consumer_usage);
          errors++;
        end
      end
    end
  end

  function automatic in_t rand_item(logic [2:0] f);
    in_t it;
    it.func = f;
    it.keyboard_report = {$urandom, $urandom};
    it.mouse_buttons = 8'($urandom);
    it.mouse_dx = 8'($urandom);
    it.mouse_dy = 8'($urandom);
    it.mouse_wheel = 8'($urandom);
    it.consumer_usage = 16'($urandom);
    case ($urandom_range(3))
      0: it.elapsed_ticks = 16'($urandom);
      1: it.elapsed_ticks = 16'($urandom_range(4));
      default: it.elapsed_ticks = 16'($urandom_range(80));
    endcase
    it.usb_configured = ($urandom_range(9) != 0);
    it.keyboard_ready = ($urandom_range(4) != 0);
    it.mouse_ready = ($urandom_range(4) != 0);
    it.consumer_ready = ($urandom_range(4) != 0);
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || sent_reports.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [9:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (v == Rate125 || v == Rate250 || v == Rate500 || v == Rate1000) begin
      rate = v;
      phase = 0;
    end
  endtask

  task automatic random_burst(int n);
    logic [2:0] f;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 18) f = FuncKeyboard;
      else if (r < 45) f = FuncMouse;
      else if (r < 60) f = FuncConsumer;
      else if (r < 63) f = FuncRelease;
      else if (r < 97) f = FuncTick;
      else f = 3'($urandom_range(5, 7));
      pending_items.push_back(rand_item(f));
    end
  endtask

  initial begin
    in_t it;
    logic [9:0] rates [4];
    rates = '{Rate125, Rate250, Rate500, Rate1000};
    errors = 0;
    shadow_clear();
    phase = 0;
    rate = RateReset;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_taken = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    recv_hold = 0;
    send_idle_pct = 20;
    recv_idle_pct = 52;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every function, merge clamp, release, idle ticks.
    it = rand_item(FuncKeyboard);
    it.keyboard_report = '1;
    pending_items.push_back(it);
    it.keyboard_report = '0;
    pending_items.push_back(it);
    it = rand_item(FuncConsumer);
    it.consumer_usage = 16'hFFFF;
    pending_items.push_back(it);
    for (int k = 0; k < 18; k++) begin
      it = rand_item(FuncMouse);
      it.mouse_dx = (k % 2) ? 8'sh7F : 8'sh80;
      it.mouse_dy = 8'sh7F;
      it.mouse_wheel = 8'sh80;
      pending_items.push_back(it);
    end
    it = rand_item(FuncTick);
    it.usb_configured = 1'b0;
    pending_items.push_back(it);
    it.usb_configured = 1'b1;
    it.elapsed_ticks = 16'hFFFF;
    {it.keyboard_ready, it.mouse_ready, it.consumer_ready} = 3'b111;
    pending_items.push_back(it);
    it.elapsed_ticks = 16'd1;
    pending_items.push_back(it);
    pending_items.push_back(rand_item(FuncRelease));
    pending_items.push_back(rand_item(3'd7));
    drain();

    write_rate(10'd999);
    write_rate(Rate125);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 52;
        recv_idle_pct = 20;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int s = 0; s < 4; s++) begin
        random_burst(150);
        if (ph == 0 && s == 1) recv_hold = 300;
        drain();
        write_rate(s == 3 ? 10'($urandom) : rates[$urandom_range(3)]);
      end
    end
    write_rate(Rate1000);
    random_burst(50);
    drain();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
